// ----- rtl/elt_pkg.sv -----
// ----------------------------------------------------------------------------
// elt_pkg: shared types and constants
// Word widths, register codes and cell control for the echo level filter.
// ----------------------------------------------------------------------------
package elt_pkg;

  // field widths
  localparam int ECHO_W = 20;
  localparam int DIST_W = 8;
  localparam int PCT_W  = 7;
  localparam int CFG_W  = 16;

  // configuration register codes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL  = 1'b1;

  // percentage divider widths
  localparam int NUM_W     = 24;
  localparam int DEN_W     = 17;
  localparam int DIV_CNT_W = 5;

  // echo scaling: cm = floor(floor(t/2) * 10 / 291)
  // by the reciprocal ceil(10 * 2^28 / 291), exact for any 19-bit half time
  localparam int                 RECIP_W    = 24;
  localparam int                 ECHO_SHIFT = 28;
  localparam logic [RECIP_W-1:0] ECHO_RECIP = 24'd9224587;
  localparam logic [PCT_W-1:0]   PCT_FULL   = 7'd100;
  localparam logic [PCT_W-1:0]   PCT_NONE   = 7'd0;

  // control handed to each cell of the sorting row
  typedef struct packed {
    logic ins;   // insert a new word in sorted place
    logic shf;   // shift the row one place toward the tail
  } cell_ctrl_t;

endpackage

// ----- rtl/elt_cell.sv -----
// ----------------------------------------------------------------------------
// elt_cell: one cell of the sorting row
// Holds one distance; on insert it keeps, takes the left neighbor, or takes
// the new word, so the row stays in ascending order. On shift it always takes
// the left neighbor.
// ----------------------------------------------------------------------------
module elt_cell (
  input  logic                        clk,
  input  elt_pkg::cell_ctrl_t         ctrl,
  input  logic [elt_pkg::DIST_W-1:0]  new_word,
  input  logic [elt_pkg::DIST_W-1:0]  left_val,
  input  logic                        left_gt,
  input  logic                        empty,
  output logic [elt_pkg::DIST_W-1:0]  val,
  output logic                        gt
);
  import elt_pkg::*;

  logic [DIST_W-1:0] val_r;
  logic [DIST_W-1:0] val_nxt;

  // an empty cell counts as above any new word
  assign gt  = empty || (val_r > new_word);
  assign val = val_r;

  // next value
  always_comb begin
    val_nxt = val_r;
    if (ctrl.shf) begin
      val_nxt = left_val;
    end else if (ctrl.ins && gt) begin
      val_nxt = left_gt ? left_val : new_word;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ----- rtl/elt_div.sv -----
// ----------------------------------------------------------------------------
// elt_div: restoring divider
// Unsigned divide, one quotient bit per cycle.
// done pulses for one cycle with the quotient on quo.
// ----------------------------------------------------------------------------
module elt_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [elt_pkg::NUM_W-1:0]  num,
  input  logic [elt_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [elt_pkg::NUM_W-1:0]  quo
);
  import elt_pkg::*;

  logic                 run_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0]     den_r;
  logic [DEN_W-1:0]     rem_r;
  logic [NUM_W-1:0]     quo_r;

  logic [DEN_W:0]       shifted;
  logic                 ge;
  logic [DEN_W:0]       diff;

  // one restoring step
  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(NUM_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (go) begin
      den_r <= den;
      rem_r <= '0;
      quo_r <= num;
    end else if (run_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ----- rtl/echo_level_trimmed_mean.sv -----
// ----------------------------------------------------------------------------
// echo_level_trimmed_mean: trimmed-mean tank level from echo times
// Converts echo times to distances, sorts each group in a row of cells and
// reports the trimmed mean distance and the fill percentage.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_echo_time_us and raise start; the word is taken at a
//   clock edge with start high and busy low. The distance is latched at that
//   edge, so the input may change right after it.
//   An echo is scaled by a reciprocal multiply at the accepting edge and
//   inserted in sorted place into the cell row at the next edge; busy is high
//   while it is inserted, so no new echo is taken until the insert is done.
//   After the SAMPLE_COUNT-th echo of a group the row drains through its
//   tail, the mean is registered and the percentage is decided directly
//   or through the serial divider.
//   Output: out_valid is high for exactly one cycle with the mean and fill
//   words; busy stays high through the strobe cycle. The receiver cannot
//   stall, so the word must be taken then.
//   Config: cfg_we writes cfg_wdata into the register cfg_index selects;
//   write only while busy is low.
//   Reset: rst_n low clears the group count, the control state and both
//   distance registers; the sample row holds no valid data until filled.
// ----------------------------------------------------------------------------
module echo_level_trimmed_mean #(
  parameter int SAMPLE_COUNT    = 10,
  parameter int TRIM_EACH_SIDE  = 2,
  parameter int MAX_DISTANCE_CM = 200
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [elt_pkg::ECHO_W-1:0]    in_echo_time_us,
  output logic                          out_valid,
  output logic [elt_pkg::DIST_W-1:0]    out_mean_distance_cm,
  output logic [elt_pkg::PCT_W-1:0]     out_fill_percent,
  input  logic                          cfg_we,
  input  logic [elt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [elt_pkg::CFG_W-1:0]     cfg_wdata
);
  import elt_pkg::*;

  localparam int TRIM_EFF = (2 * TRIM_EACH_SIDE >= SAMPLE_COUNT) ?
                            (SAMPLE_COUNT - 1) / 2 : TRIM_EACH_SIDE;
  localparam int KEPT     = SAMPLE_COUNT - 2 * TRIM_EFF;
  localparam int CNT_W    = $clog2(SAMPLE_COUNT);
  localparam int SUM_W    = DIST_W + $clog2(SAMPLE_COUNT);
  localparam int SW       = CFG_W + 2;
  // mean by reciprocal: exact while sum * (MEAN_MUL * KEPT - 2^MEAN_SH) < 2^MEAN_SH
  localparam int MEAN_SH  = SUM_W + 6;
  localparam int MEAN_MUL = ((1 << MEAN_SH) + KEPT - 1) / KEPT;
  localparam int MPROD_W  = SUM_W + MEAN_SH + 1;
  localparam int EPROD_W  = ECHO_W - 1 + RECIP_W;
  localparam int QUO_W    = EPROD_W - ECHO_SHIFT;

  typedef enum logic [2:0] {
    S_IDLE, S_ECHO, S_DRAIN, S_MEAN, S_PCT, S_PCT_DIV, S_OUT
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  drain_r;
  logic [SUM_W-1:0]  sum_r;
  logic [DIST_W-1:0] dist_r;
  logic [DIST_W-1:0] mean_r;
  logic [PCT_W-1:0]  pct_r;
  logic [CFG_W-1:0]  empty_r;
  logic [CFG_W-1:0]  full_r;

  logic              div_go;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic              div_done;
  logic [NUM_W-1:0]  div_quo;

  cell_ctrl_t        cell_ctrl;
  logic [DIST_W-1:0] dist_w;
  logic [DIST_W-1:0] cell_val [SAMPLE_COUNT];
  logic              cell_gt  [SAMPLE_COUNT];
  logic              cell_empty [SAMPLE_COUNT];

  logic [ECHO_W-2:0]  half_w;
  logic [EPROD_W-1:0] echo_prod;
  logic [QUO_W-1:0]   echo_cm;
  logic               keep_w;
  logic [SUM_W-1:0]   sum_nxt;
  logic [MPROD_W-1:0] mean_prod;
  logic [DIST_W-1:0]  mean_w;

  logic signed [SW-1:0] e_s, f_s, m_s, range_s, diff_s, a_s, b_s;
  logic                 pct_direct;
  logic [PCT_W-1:0]     pct_direct_val;

  // percentage divider
  elt_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  // echo scaling: floor(t/2) * 10 / 291 by reciprocal multiply
  assign half_w    = in_echo_time_us[ECHO_W-1:1];
  assign echo_prod = EPROD_W'(half_w) * EPROD_W'(ECHO_RECIP);
  assign echo_cm   = echo_prod[EPROD_W-1:ECHO_SHIFT];

  // out of range distance stored as zero
  assign dist_w = ((echo_cm == '0) || (echo_cm >= QUO_W'(MAX_DISTANCE_CM))) ?
                  '0 : echo_cm[DIST_W-1:0];

  // cell row control
  always_comb begin
    cell_ctrl.ins = (state_r == S_ECHO);
    cell_ctrl.shf = (state_r == S_DRAIN);
  end

  // row of sorting cells, ascending from cell 0
  for (genvar i = 0; i < SAMPLE_COUNT; i++) begin : g_cell
    assign cell_empty[i] = (CNT_W'(i) >= count_r);
    if (i == 0) begin : g_head
      elt_cell u_cell (
        .clk     (clk),
        .ctrl    (cell_ctrl),
        .new_word(dist_r),
        .left_val(dist_r),
        .left_gt (1'b0),
        .empty   (cell_empty[i]),
        .val     (cell_val[i]),
        .gt      (cell_gt[i])
      );
    end else begin : g_body
      elt_cell u_cell (
        .clk     (clk),
        .ctrl    (cell_ctrl),
        .new_word(dist_r),
        .left_val(cell_val[i-1]),
        .left_gt (cell_gt[i-1]),
        .empty   (cell_empty[i]),
        .val     (cell_val[i]),
        .gt      (cell_gt[i])
      );
    end
  end

  // drain accumulation, largest first from the tail
  assign keep_w  = (drain_r >= CNT_W'(TRIM_EFF)) &&
                   (drain_r <= CNT_W'(SAMPLE_COUNT - 1 - TRIM_EFF));
  assign sum_nxt = sum_r + (keep_w ? SUM_W'(cell_val[SAMPLE_COUNT-1]) : '0);

  // truncated mean of the kept words
  assign mean_prod = MPROD_W'(sum_r) * MPROD_W'(MEAN_MUL);
  assign mean_w    = mean_prod[MEAN_SH +: DIST_W];

  // fill percentage operands, sign folded into a and b
  always_comb begin
    e_s     = SW'($signed(empty_r));
    f_s     = SW'($signed(full_r));
    m_s     = $signed({{(SW - DIST_W){1'b0}}, mean_r});
    range_s = e_s - f_s;
    diff_s  = e_s - m_s;
    if (range_s < 0) begin
      a_s = -diff_s;
      b_s = -range_s;
    end else begin
      a_s = diff_s;
      b_s = range_s;
    end
    pct_direct     = 1'b1;
    pct_direct_val = PCT_NONE;
    if (range_s == 0) begin
      pct_direct_val = (m_s > f_s) ? PCT_NONE : PCT_FULL;
    end else if (a_s <= 0) begin
      pct_direct_val = PCT_NONE;
    end else if (a_s >= b_s) begin
      pct_direct_val = PCT_FULL;
    end else begin
      pct_direct = 1'b0;
    end
  end

  // divider operands, percentage only
  always_comb begin
    div_go  = 1'b0;
    div_num = NUM_W'(a_s[DEN_W-1:0]) * NUM_W'(PCT_FULL);
    div_den = b_s[DEN_W-1:0];
    case (state_r)
      S_PCT: begin
        div_go = !pct_direct;
      end
      default: begin
        div_go = 1'b0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_r <= '0;
      full_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EMPTY: empty_r <= cfg_wdata;
        REG_FULL:  full_r  <= cfg_wdata;
        default:   empty_r <= empty_r;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      drain_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) state_r <= S_ECHO;
        end
        S_ECHO: begin
          if (count_r == CNT_W'(SAMPLE_COUNT - 1)) begin
            count_r <= '0;
            drain_r <= '0;
            state_r <= S_DRAIN;
          end else begin
            count_r <= count_r + 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_DRAIN: begin
          drain_r <= drain_r + 1'b1;
          if (drain_r == CNT_W'(SAMPLE_COUNT - 1)) state_r <= S_MEAN;
        end
        S_MEAN: begin
          state_r <= S_PCT;
        end
        S_PCT: begin
          state_r <= pct_direct ? S_OUT : S_PCT_DIV;
        end
        S_PCT_DIV: begin
          if (div_done) state_r <= S_OUT;
        end
        S_OUT: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // result datapath
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && start) begin
      dist_r <= dist_w;
    end
    if (state_r == S_ECHO) begin
      sum_r <= '0;
    end else if (state_r == S_DRAIN) begin
      sum_r <= sum_nxt;
    end
    if (state_r == S_MEAN) begin
      mean_r <= mean_w;
    end
    if (state_r == S_PCT) begin
      pct_r <= pct_direct_val;
    end else if ((state_r == S_PCT_DIV) && div_done) begin
      pct_r <= div_quo[PCT_W-1:0];
    end
  end

  assign busy                 = (state_r != S_IDLE);
  assign out_valid            = (state_r == S_OUT);
  assign out_mean_distance_cm = mean_r;
  assign out_fill_percent     = pct_r;

  // checks
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fill_percent <= PCT_FULL))
    else $error("fill percentage above full");

  a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mean_distance_cm < DIST_W'(MAX_DISTANCE_CM)))
    else $error("mean distance out of range");

endmodule

// ----- tb/sv/echo_level_trimmed_mean_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_level_trimmed_mean_test: self-checking bench for the echo level filter
// Feeds echo times through the start/busy port and predicts every level word.
// Each word is checked field by field against the prediction. The run covers
// several empty/full settings, among them the register extremes.
// ----------------------------------------------------------------------------
module echo_level_trimmed_mean_test;
  import elt_pkg::*;

  localparam int SAMPLES        = 10;
  localparam int TRIM           = 2;
  localparam int MAX_CM         = 200;
  localparam int ITEMS_PER_STEP = 88;
  localparam int DRAIN_CYCLES   = 120;
  localparam int WATCHDOG_LIMIT = 2000;

  // corner echoes: timeout, both sides of 1 cm and 199 cm, out of range values
  localparam logic [ECHO_W-1:0] CORNER_ECHOES [23] = '{
    20'd0, 20'd1, 20'd59, 20'd60, 20'd11639,
    20'd11640, 20'hFFFFF, 20'd58, 20'd11638, 20'd5820,
    20'd0, 20'd1, 20'd57, 20'd58, 20'd59,
    20'd11640, 20'd11641, 20'hFFFFF, 20'h80000, 20'h40000,
    20'd11639, 20'd11582, 20'd11581
  };

  // predicts the level words and checks them in order
  class level_scoreboard;
    typedef struct {
      logic [DIST_W-1:0] mean;
      logic [PCT_W-1:0]  pct;
    } level_t;

    level_t            levels_due[$];
    logic [DIST_W-1:0] group_cm [SAMPLES];
    int                group_fill;
    shortint           empty_cm;
    shortint           full_cm;
    int                errors;

    function new();
      group_fill = 0;
      empty_cm   = 16'sd0;
      full_cm    = 16'sd0;
      errors     = 0;
    endfunction

    function void set_levels(shortint empty_val, shortint full_val);
      empty_cm = empty_val;
      full_cm  = full_val;
    endfunction

    function int pending();
      return levels_due.size();
    endfunction

    // half the echo time over 29.1 us/cm; zero and out of range give 0
    function logic [DIST_W-1:0] distance_of_echo(logic [ECHO_W-1:0] echo);
      int unsigned cm;
      cm = ((echo >> 1) * 10) / 291;
      if (cm == 0 || cm >= MAX_CM) return '0;
      return DIST_W'(cm);
    endfunction

    // exact fill percentage, clamped to 0..100
    function logic [PCT_W-1:0] percent_full(int unsigned mean);
      longint span, over, num, den;
      span = longint'(empty_cm) - longint'(full_cm);
      over = longint'(mean) - longint'(full_cm);
      if (span == 0) return (over > 0) ? PCT_NONE : PCT_FULL;
      num = 100 * (span - over);
      den = span;
      if (den < 0) begin
        num = -num;
        den = -den;
      end
      if (num <= 0) return PCT_NONE;
      if (num >= 100 * den) return PCT_FULL;
      return PCT_W'(num / den);
    endfunction

    // store one accepted echo; a full group yields one level word
    function void note_echo(logic [ECHO_W-1:0] echo);
      logic [DIST_W-1:0] sorted [SAMPLES];
      logic [DIST_W-1:0] v;
      int                j, trim, kept;
      int unsigned       sum;
      level_t            lvl;
      group_cm[group_fill] = distance_of_echo(echo);
      group_fill++;
      if (group_fill < SAMPLES) return;
      group_fill = 0;
      sorted = group_cm;
      for (int i = 1; i < SAMPLES; i++) begin
        v = sorted[i];
        j = i;
        while (j > 0 && sorted[j-1] > v) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = v;
      end
      // keep at least one sample when the trim would eat the whole group
      trim = (2 * TRIM >= SAMPLES) ? (SAMPLES - 1) / 2 : TRIM;
      kept = SAMPLES - 2 * trim;
      sum  = 0;
      for (int i = trim; i < trim + kept; i++) sum += sorted[i];
      lvl.mean = DIST_W'(sum / kept);
      lvl.pct  = percent_full(sum / kept);
      levels_due.push_back(lvl);
    endfunction

    function void check_level(logic [DIST_W-1:0] mean, logic [PCT_W-1:0] pct);
      level_t lvl;
      if (levels_due.size() == 0) begin
        $display("%0t: unexpected level word, actual mean %0d fill %0d",
                 $time, mean, pct);
        errors++;
        return;
      end
      lvl = levels_due.pop_front();
      if (mean !== lvl.mean) begin
        $display("%0t: mean_distance_cm mismatch, expected %0d, actual %0d",
                 $time, lvl.mean, mean);
        errors++;
      end
      if (pct !== lvl.pct) begin
        $display("%0t: fill_percent mismatch, expected %0d, actual %0d",
                 $time, lvl.pct, pct);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n           = 1'b0;
  logic                 start           = 1'b0;
  logic                 busy;
  logic [ECHO_W-1:0]    in_echo_time_us = '0;
  logic                 out_valid;
  logic [DIST_W-1:0]    out_mean_distance_cm;
  logic [PCT_W-1:0]     out_fill_percent;
  logic                 cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index       = REG_EMPTY;
  logic [CFG_W-1:0]     cfg_wdata       = '0;

  level_scoreboard sb;
  int              echo_seq    = 0;
  int              quiet_count = 0;

  echo_level_trimmed_mean #(
    .SAMPLE_COUNT    (SAMPLES),
    .TRIM_EACH_SIDE  (TRIM),
    .MAX_DISTANCE_CM (MAX_CM)
  ) i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_echo_time_us      (in_echo_time_us),
    .out_valid            (out_valid),
    .out_mean_distance_cm (out_mean_distance_cm),
    .out_fill_percent     (out_fill_percent),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // result check and watchdog, sampled mid-cycle where all signals are settled
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_level(out_mean_distance_cm, out_fill_percent);
      if ((start && !busy) || out_valid) quiet_count = 0;
      else quiet_count++;
      if (quiet_count >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no word moved in %0d cycles, %0d levels due",
                 $time, quiet_count, sb.pending());
        $display("FAIL");
        $finish;
      end
    end
  end

  // offer one echo and return at the edge that takes it, start left high
  task automatic send_echo(input logic [ECHO_W-1:0] echo);
    start           <= 1'b1;
    in_echo_time_us <= echo;
    @(negedge clk);
    while (busy) @(negedge clk);
    sb.note_echo(echo);
    echo_seq++;
    @(posedge clk);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // wait for every due level word and an idle block, then let it drain
  task automatic settle(input int tail);
    start <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0 || busy) @(negedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_levels(input shortint empty_val, input shortint full_val);
    cfg_we    <= 1'b1;
    cfg_index <= REG_EMPTY;
    cfg_wdata <= empty_val;
    @(posedge clk);
    cfg_index <= REG_FULL;
    cfg_wdata <= full_val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_levels(empty_val, full_val);
  endtask

  // mostly clustered echoes, with timeouts, full-width noise and edge values
  function automatic logic [ECHO_W-1:0] draw_echo(int style, int base, int spread);
    int          pick;
    int unsigned half;
    pick = $urandom_range(0, 99);
    if (pick < 8) return '0;
    if (pick < 16) return ECHO_W'($urandom_range(0, 20'hFFFFF));
    if (pick < 22) begin
      case ($urandom_range(0, 9))
        0:       return 20'd58;
        1:       return 20'd59;
        2:       return 20'd60;
        3:       return 20'd61;
        4:       return 20'd11581;
        5:       return 20'd11582;
        6:       return 20'd11638;
        7:       return 20'd11639;
        8:       return 20'd11640;
        default: return 20'd11641;
      endcase
    end
    case (style)
      0:       half = $urandom_range(0, 5900);
      1:       half = $urandom_range(5791, 5819);
      default: half = base + $urandom_range(0, spread);
    endcase
    return ECHO_W'({half, 1'b0}) | ECHO_W'($urandom_range(0, 1));
  endfunction

  task automatic run_random(input int count, input bit may_idle, input int pause_at);
    int style, base, spread;
    bit bursty;
    style  = 2;
    base   = 0;
    spread = 0;
    bursty = 1'b0;
    for (int n = 0; n < count; n++) begin
      if (n == pause_at) settle(1);
      // new group: new spread of distances and a new idling mood
      if (echo_seq % SAMPLES == 0) begin
        style  = ($urandom_range(0, 9) == 0) ? 1 : ($urandom_range(0, 3) == 0 ? 0 : 2);
        base   = $urandom_range(0, 5800);
        spread = $urandom_range(0, 600);
        bursty = may_idle && ($urandom_range(0, 2) != 0);
      end
      if (bursty && $urandom_range(0, 2) == 0) hold_off($urandom_range(1, 17));
      send_echo(draw_echo(style, base, spread));
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner echoes under the reset setting, where empty equals full
    foreach (CORNER_ECHOES[k]) send_echo(CORNER_ECHOES[k]);
    run_random(ITEMS_PER_STEP - 23, 1'b1, -1);

    settle(DRAIN_CYCLES);
    write_levels(16'sd200, 16'sd20);
    run_random(ITEMS_PER_STEP, 1'b1, -1);

    // full farther than empty
    settle(DRAIN_CYCLES);
    write_levels(16'sd20, 16'sd200);
    run_random(ITEMS_PER_STEP, 1'b1, -1);

    // register extremes, with one full pause partway
    settle(DRAIN_CYCLES);
    write_levels(16'sh7FFF, -16'sh8000);
    run_random(ITEMS_PER_STEP, 1'b1, 45);

    settle(DRAIN_CYCLES);
    write_levels(-16'sh8000, 16'sh7FFF);
    run_random(ITEMS_PER_STEP, 1'b1, -1);

    settle(DRAIN_CYCLES);
    write_levels(16'sd100, 16'sd100);
    run_random(ITEMS_PER_STEP, 1'b1, -1);

    settle(DRAIN_CYCLES);
    write_levels(shortint'($urandom_range(0, 290)) - 16'sd40,
                 shortint'($urandom_range(0, 290)) - 16'sd40);
    run_random(ITEMS_PER_STEP, 1'b1, -1);

    // closing stretch at full rate
    settle(DRAIN_CYCLES);
    write_levels(16'sd150, 16'sd10);
    run_random(ITEMS_PER_STEP, 1'b0, -1);

    settle(DRAIN_CYCLES);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
